// ===== design/raeu_pkg.sv =====
// Shared constants, operation codes and types of the register ALU execute unit.
`default_nettype none

package raeu_pkg;

    localparam int NUM_REGS_DEF   = 6;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [4:0] OP_LOAD    = 5'd0;
    localparam logic [4:0] OP_MOVE    = 5'd1;
    localparam logic [4:0] OP_ADD     = 5'd2;
    localparam logic [4:0] OP_SUB     = 5'd3;
    localparam logic [4:0] OP_MUL     = 5'd4;
    localparam logic [4:0] OP_MOD     = 5'd5;
    localparam logic [4:0] OP_DIV     = 5'd6;
    localparam logic [4:0] OP_INC     = 5'd7;
    localparam logic [4:0] OP_DEC     = 5'd8;
    localparam logic [4:0] OP_EQ      = 5'd9;
    localparam logic [4:0] OP_GE      = 5'd10;
    localparam logic [4:0] OP_LE      = 5'd11;
    localparam logic [4:0] OP_JUMPREG = 5'd12;
    localparam logic [4:0] OP_JZ      = 5'd13;
    localparam logic [4:0] OP_JNZ     = 5'd14;
    localparam logic [4:0] OP_SHIFT   = 5'd15;
    localparam logic [4:0] OP_NOP     = 5'd16;
    localparam logic [4:0] OP_FINISH  = 5'd17;

    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_ABORT  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [1:0] MDU_MUL = 2'd0;
    localparam logic [1:0] MDU_DIV = 2'd1;
    localparam logic [1:0] MDU_REM = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] kind;
    } mdu_cmd_t;

endpackage

`default_nettype wire

// ===== design/raeu_req_if.sv =====
// Instruction request channel.
`default_nettype none

interface raeu_req_if;
    logic               valid;
    logic               ready;
    logic        [4:0]  req_type;
    logic        [2:0]  dest_index;
    logic        [2:0]  src_index;
    logic signed [31:0] imm_value;
    logic        [31:0] branch_target;
    logic        [3:0]  instr_len;

    modport source (
        output valid, req_type, dest_index, src_index, imm_value, branch_target, instr_len,
        input  ready
    );
    modport sink (
        input  valid, req_type, dest_index, src_index, imm_value, branch_target, instr_len,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/raeu_rsp_if.sv =====
// Execution result channel.
`default_nettype none

interface raeu_rsp_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  exec_status;
    logic        [31:0] next_pc;
    logic signed [31:0] acc_value;

    modport source (
        output valid, exec_status, next_pc, acc_value,
        input  ready
    );
    modport sink (
        input  valid, exec_status, next_pc, acc_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/register_alu_execute_unit.sv =====
// Register ALU execute unit: register file memory, sequencer and result register.
// Executes one decoded instruction per request against NUM_REGS signed DATA_WIDTH-bit
// registers held in a small synchronous RAM with two read ports (register 0 is the
// accumulator), plus a program counter and a run status; each request yields one
// result (status, next pc, accumulator). Requests are handled one at a time: most
// operations pass through accept with register read, execute and write back, and
// result load, which waits while an earlier result is still held and not taken;
// multiply, divide and modulo run through a shared shift-add / restoring unit that
// retires one bit per cycle (divide and modulo by zero abort instead). A new request
// is taken while the previous result still waits in the output register. Register
// contents are zero after reset through per-entry valid bits; no clearing pass is
// needed.
`default_nettype none

module register_alu_execute_unit #(
    parameter int NUM_REGS   = raeu_pkg::NUM_REGS_DEF,
    parameter int DATA_WIDTH = raeu_pkg::DATA_WIDTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    raeu_req_if.sink   req,
    raeu_rsp_if.source rsp
);
    import raeu_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int AW  = $clog2(NUM_REGS);
    localparam int SHW = $clog2(DW);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_MDU  = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [DW-1:0] mem [NUM_REGS];

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [NUM_REGS-1:0] vld_reg;
    logic [DW-1:0]       acc_reg;
    logic [31:0]         pc_reg;
    logic [31:0]         pc_next;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic                commit;

    logic [4:0]    op_reg;
    logic [AW-1:0] di_addr_reg;
    logic          di_ok_reg;
    logic [31:0]   imm_reg;
    logic [31:0]   tgt_reg;
    logic [3:0]    len_reg;
    logic          a_ok_reg;
    logic          b_ok_reg;
    logic [DW-1:0] rd_a_reg;
    logic [DW-1:0] rd_b_reg;

    logic          rsp_valid_reg;
    logic [1:0]    rsp_status_reg;
    logic [31:0]   rsp_pc_reg;
    logic [31:0]   rsp_acc_reg;

    logic [4:0]    di_ext;
    logic [4:0]    si_ext;
    logic [AW-1:0] a_addr;
    logic [AW-1:0] b_addr;
    logic          a_in;
    logic          b_in;

    logic          wr_en;
    logic          wr_acc;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;

    logic [DW-1:0] opa;
    logic [DW-1:0] opb;
    logic [63:0]   imm64;
    logic [63:0]   opa64;
    logic [63:0]   acc64;
    logic          sh_left;
    logic [31:0]   sh_amt;
    logic          sh_big;
    logic [DW-1:0] sh_res;

    mdu_cmd_t      mdu_cmd;
    logic          mdu_done;
    logic [DW-1:0] mdu_result;

    logic          accept;
    logic          load_rsp;

    assign di_ext = {2'b00, req.dest_index};
    assign si_ext = {2'b00, req.src_index};
    assign a_addr = di_ext[AW-1:0];
    assign b_addr = si_ext[AW-1:0];
    assign a_in   = di_ext < 5'(NUM_REGS);
    assign b_in   = si_ext < 5'(NUM_REGS);

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_a_reg <= mem[a_addr];
        rd_b_reg <= mem[b_addr];
    end

    assign opa = a_ok_reg ? rd_a_reg : '0;
    assign opb = b_ok_reg ? rd_b_reg : '0;

    assign imm64   = 64'(signed'(imm_reg));
    assign opa64   = 64'(opa);
    assign acc64   = 64'(signed'(acc_reg));
    assign sh_left = imm_reg[31];
    assign sh_amt  = sh_left ? (32'd0 - imm_reg) : imm_reg;
    assign sh_big  = sh_amt >= 32'(DW);

    always_comb
    begin
        if (sh_left)
            sh_res = sh_big ? '0 : (opa << sh_amt[SHW-1:0]);
        else
            sh_res = sh_big ? {DW{opa[DW-1]}} : DW'($signed(opa) >>> sh_amt[SHW-1:0]);
    end

    always_comb
    begin
        state_next   = state_reg;
        wr_en        = 1'b0;
        wr_acc       = 1'b1;
        wr_data      = opa;
        pc_next      = pc_reg + 32'(len_reg);
        status_next  = status_reg;
        commit       = 1'b0;
        mdu_cmd      = '{start: 1'b0, kind: MDU_MUL};
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                if (status_reg == ST_RUN)
                begin
                    commit = 1'b1;
                    unique case (op_reg)
                        OP_LOAD:
                        begin
                            wr_en   = 1'b1;
                            wr_acc  = 1'b0;
                            wr_data = imm64[DW-1:0];
                        end
                        OP_MOVE:
                        begin
                            wr_en   = 1'b1;
                            wr_acc  = 1'b0;
                            wr_data = opb;
                        end
                        OP_ADD:
                        begin
                            wr_en   = 1'b1;
                            wr_data = opa + opb;
                        end
                        OP_SUB:
                        begin
                            wr_en   = 1'b1;
                            wr_data = opa - opb;
                        end
                        OP_MUL:
                        begin
                            mdu_cmd    = '{start: 1'b1, kind: MDU_MUL};
                            state_next = S_MDU;
                        end
                        OP_MOD, OP_DIV:
                        begin
                            if (opb == '0)
                            begin
                                status_next = ST_ABORT;
                                pc_next     = pc_reg;
                            end
                            else
                            begin
                                mdu_cmd = '{start: 1'b1,
                                            kind: (op_reg == OP_MOD) ? MDU_REM : MDU_DIV};
                                state_next = S_MDU;
                            end
                        end
                        OP_INC:
                        begin
                            wr_en   = 1'b1;
                            wr_acc  = 1'b0;
                            wr_data = opa + DW'(1);
                        end
                        OP_DEC:
                        begin
                            wr_en   = 1'b1;
                            wr_acc  = 1'b0;
                            wr_data = opa - DW'(1);
                        end
                        OP_EQ:
                        begin
                            wr_en   = 1'b1;
                            wr_data = DW'(opa == opb);
                        end
                        OP_GE:
                        begin
                            wr_en   = 1'b1;
                            wr_data = DW'($signed(opa) >= $signed(opb));
                        end
                        OP_LE:
                        begin
                            wr_en   = 1'b1;
                            wr_data = DW'($signed(opb) >= $signed(opa));
                        end
                        OP_JUMPREG:
                            pc_next = opa64[31:0];
                        OP_JZ:
                        begin
                            if (acc_reg == '0)
                                pc_next = tgt_reg;
                        end
                        OP_JNZ:
                        begin
                            if (acc_reg != '0)
                                pc_next = tgt_reg;
                        end
                        OP_SHIFT:
                        begin
                            wr_en   = 1'b1;
                            wr_acc  = 1'b0;
                            wr_data = sh_res;
                        end
                        OP_FINISH:
                            status_next = ST_FINISH;
                        default:
                        begin
                        end
                    endcase
                    if (!wr_acc && !di_ok_reg)
                        wr_en = 1'b0;
                end
            end
            S_MDU:
            begin
                if (mdu_done)
                begin
                    wr_en      = 1'b1;
                    wr_data    = mdu_result;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (load_rsp)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign wr_addr  = wr_acc ? '0 : di_addr_reg;
    assign load_rsp = (state_reg == S_RESP) && (!rsp_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vld_reg       <= '0;
            acc_reg       <= '0;
            pc_reg        <= '0;
            status_reg    <= ST_RUN;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
                if (wr_addr == '0)
                    acc_reg <= wr_data;
            end
            if (commit)
            begin
                pc_reg     <= pc_next;
                status_reg <= status_next;
            end
            if (load_rsp)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= req.req_type;
            di_addr_reg <= a_addr;
            di_ok_reg   <= a_in;
            imm_reg     <= req.imm_value;
            tgt_reg     <= req.branch_target;
            len_reg     <= req.instr_len;
            a_ok_reg    <= a_in && vld_reg[a_addr];
            b_ok_reg    <= b_in && vld_reg[b_addr];
        end
        if (load_rsp)
        begin
            rsp_status_reg <= status_reg;
            rsp_pc_reg     <= pc_reg;
            rsp_acc_reg    <= acc64[31:0];
        end
    end

    raeu_mdu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mdu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (mdu_cmd),
        .opa    (opa),
        .opb    (opb),
        .done   (mdu_done),
        .result (mdu_result)
    );

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.exec_status = rsp_status_reg;
    assign rsp.next_pc     = rsp_pc_reg;
    assign rsp.acc_value   = signed'(rsp_acc_reg);

endmodule

`default_nettype wire

// ===== design/raeu_mdu.sv =====
// Iterative multiply / divide / remainder unit, one bit per cycle.
`default_nettype none

module raeu_mdu #(
    parameter int DATA_WIDTH = raeu_pkg::DATA_WIDTH_DEF
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  raeu_pkg::mdu_cmd_t         cmd,
    input  wire  [DATA_WIDTH-1:0]      opa,
    input  wire  [DATA_WIDTH-1:0]      opb,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      result
);
    import raeu_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg;
    logic [1:0]    kind_reg;
    logic [DW-1:0] lo_reg;
    logic [DW-1:0] hi_reg;
    logic [DW-1:0] dv_reg;
    logic          neg_q_reg;
    logic          neg_r_reg;
    logic          done_reg;

    logic [DW-1:0] hi_next;
    logic [DW-1:0] lo_next;
    logic [DW:0]   rem_shift;
    logic [DW+1:0] diff;
    logic          fits;
    logic [DW-1:0] abs_a;
    logic [DW-1:0] abs_b;

    assign abs_a     = opa[DW-1] ? (DW'(0) - opa) : opa;
    assign abs_b     = opb[DW-1] ? (DW'(0) - opb) : opb;
    assign rem_shift = {hi_reg, lo_reg[DW-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dv_reg};
    assign fits      = !diff[DW+1];

    always_comb
    begin
        if (kind_reg == MDU_MUL)
        begin
            hi_next = hi_reg + (lo_reg[0] ? dv_reg : DW'(0));
            lo_next = lo_reg >> 1;
        end
        else
        begin
            hi_next = fits ? diff[DW-1:0] : rem_shift[DW-1:0];
            lo_next = {lo_reg[DW-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (cmd.start)
                cnt_reg <= CW'(DW);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            kind_reg  <= cmd.kind;
            hi_reg    <= '0;
            neg_q_reg <= opa[DW-1] ^ opb[DW-1];
            neg_r_reg <= opa[DW-1];
            if (cmd.kind == MDU_MUL)
            begin
                lo_reg <= opb;
                dv_reg <= opa;
            end
            else
            begin
                lo_reg <= abs_a;
                dv_reg <= abs_b;
            end
        end
        else if (cnt_reg != '0)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
            if (kind_reg == MDU_MUL)
                dv_reg <= dv_reg << 1;
        end
    end

    always_comb
    begin
        unique case (kind_reg)
            MDU_MUL: result = hi_reg;
            MDU_DIV: result = neg_q_reg ? (DW'(0) - lo_reg) : lo_reg;
            MDU_REM: result = neg_r_reg ? (DW'(0) - hi_reg) : hi_reg;
            default: result = hi_reg;
        endcase
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== design/raeu_checker.sv =====
// Port-level assertions for the register ALU execute unit, with its bind.
`default_nettype none

module raeu_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        req_valid,
    input wire        req_ready,
    input wire        rsp_valid,
    input wire        rsp_ready,
    input wire [1:0]  exec_status,
    input wire [31:0] next_pc,
    input wire [31:0] acc_value
);
    import raeu_pkg::*;

    logic [1:0]  pend_reg;
    logic        halt_reg;
    logic [1:0]  halt_status_reg;
    logic [31:0] halt_pc_reg;
    logic        req_acc;
    logic        rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg        <= '0;
            halt_reg        <= 1'b0;
            halt_status_reg <= ST_RUN;
            halt_pc_reg     <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(req_acc) - 2'(rsp_acc);
            if (rsp_acc && !halt_reg && exec_status != ST_RUN)
            begin
                halt_reg        <= 1'b1;
                halt_status_reg <= exec_status;
                halt_pc_reg     <= next_pc;
            end
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(exec_status) && $stable(next_pc)
            && $stable(acc_value))
        else $error("result changed while stalled");

    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("result without an outstanding request");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 2'd2)
        else $error("more than two requests outstanding");

    a_halt_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && halt_reg |-> exec_status == halt_status_reg)
        else $error("status left aborted or finished");

    a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && halt_reg |-> next_pc == halt_pc_reg)
        else $error("program counter moved while halted");

endmodule

bind register_alu_execute_unit raeu_checker u_raeu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .exec_status (rsp.exec_status),
    .next_pc     (rsp.next_pc),
    .acc_value   (rsp.acc_value)
);

`default_nettype wire
